@@ sv/set_assoc_transposition_table_defines.svh @@
// assertion macros shared by the checker
`ifndef SET_ASSOC_TRANSPOSITION_TABLE_DEFINES_SVH
`define SET_ASSOC_TRANSPOSITION_TABLE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SATTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SATTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sattt_pkg.sv @@
`default_nettype none
package sattt_pkg;

  localparam int NUM_WAYS   = 4;
  localparam int WAY_W      = 2;
  localparam int IN_DATA_W  = 160;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  // request kinds
  typedef enum logic [1:0] {
    REQ_PROBE_SCORE = 2'd0,
    REQ_PROBE_MOVE  = 2'd1,
    REQ_STORE       = 2'd2,
    REQ_AGE         = 2'd3
  } req_kind_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE      = 2'd3;

  // bound kinds
  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;

  // one table entry
  typedef struct packed {
    logic [31:0]        tag;
    logic [6:0]         depth;
    logic signed [15:0] score;
    logic [1:0]         bound;
    logic signed [15:0] eval;
    logic [6:0]         ply;
    logic [15:0]        move;
    logic [7:0]         age;
  } entry_t;

  // latched request
  typedef struct packed {
    req_kind_t          kind;
    logic [63:0]        key;
    logic [6:0]         search_depth;
    logic signed [15:0] alpha_bound;
    logic signed [15:0] beta_bound;
    logic signed [15:0] score;
    logic [1:0]         bound_kind;
    logic signed [15:0] eval;
    logic [6:0]         ply;
    logic [15:0]        best_move;
  } req_t;

  // configuration registers
  typedef struct packed {
    logic signed [15:0] mate_threshold;
    logic signed [15:0] mated_threshold;
    logic [7:0]         age_limit;
    logic signed [15:0] none_code;
  } cfg_t;

  // verdict of the way unit on one entry
  typedef struct packed {
    logic               hit;
    logic               empty;
    logic               deep;
    logic               none_score;
    logic               cut;
    logic signed [15:0] cut_score;
  } way_res_t;

endpackage
`default_nettype wire

@@ sv/set_assoc_transposition_table.sv @@
`default_nettype none
// Four-way set-associative transposition table. Each request (score probe,
// move probe, store, age pass) is taken on the s_ side and gives exactly one
// result transaction on the m_ side; one request is in work at a time. The
// set is the low key word modulo NUM_SETS: a registered mask when NUM_SETS is
// a power of two, otherwise reciprocal multiplication and correction. The
// ways of the set are then read one after another through the single read
// port, each way read and then evaluated, until a decision or the last way.
// The age pass reads and writes back every entry in turn before its result.
// After reset a clearing pass writes 4*NUM_SETS empty entries, one a cycle,
// before s_tready rises; configuration writes are taken throughout.
module set_assoc_transposition_table #(
  parameter int NUM_SETS = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // key, search_depth, alpha_bound, beta_bound, score, bound_kind, eval, ply,
  // best_move
  input  wire logic [sattt_pkg::IN_DATA_W-1:0]      s_tdata,
  // req_type
  input  wire logic [sattt_pkg::IN_USER_W-1:0]      s_tuser,
  input  wire logic                                 s_tvalid,
  output      logic                                 s_tready,
  // score_out, eval_out, move_out
  output      logic [sattt_pkg::OUT_DATA_W-1:0]     m_tdata,
  // score_found, eval_found, move_found
  output      logic [sattt_pkg::OUT_USER_W-1:0]     m_tuser,
  output      logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  input  wire logic                                 cfg_we,
  input  wire logic [sattt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sattt_pkg::CFG_W-1:0]          cfg_data
);
  import sattt_pkg::*;

  localparam int TABLE_SIZE = NUM_SETS * NUM_WAYS;
  localparam int ENTRY_AW   = $clog2(TABLE_SIZE);
  localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int ENTRY_W    = $bits(entry_t);
  localparam logic [ENTRY_AW-1:0] LAST_ENTRY = ENTRY_AW'(TABLE_SIZE - 1);
  localparam logic [WAY_W-1:0]    LAST_WAY   = WAY_W'(NUM_WAYS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_READ,
    ST_EVAL,
    ST_AGE_READ,
    ST_AGE_WRITE,
    ST_RESULT
  } state_t;

  state_t             state;
  req_t               req;
  req_t               in_req;
  cfg_t               cfg;
  logic [WAY_W-1:0]   way;
  logic [ENTRY_AW-1:0] cnt;
  logic               sf;
  logic               ef;
  logic               mf;
  logic signed [15:0] so;
  logic signed [15:0] eo;
  logic [15:0]        mo;
  logic signed [15:0] dflt_eval;

  logic               accept;
  logic               idx_done;
  logic [SET_W-1:0]   set_idx;
  logic [ENTRY_AW-1:0] addr_way;
  logic [ENTRY_AW-1:0] addr_dflt;
  logic               ram_we;
  logic               ram_re;
  logic [ENTRY_AW-1:0] ram_waddr;
  logic [ENTRY_AW-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             entry;
  entry_t             wr_entry;
  way_res_t           wres;
  logic               pick_now;
  logic               out_free;
  logic               eval_stop;

  assign s_tready  = state == ST_IDLE;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign entry     = entry_t'(ram_rdata);
  assign addr_way  = ENTRY_AW'({set_idx, way});
  assign addr_dflt = ENTRY_AW'({set_idx, req.key[WAY_W-1:0]});
  assign pick_now  = wres.hit || wres.empty;

  // unpack the incoming request
  always_comb begin
    in_req.kind         = req_kind_t'(s_tuser);
    in_req.key          = s_tdata[63:0];
    in_req.search_depth = s_tdata[70:64];
    in_req.alpha_bound  = s_tdata[86:71];
    in_req.beta_bound   = s_tdata[102:87];
    in_req.score        = s_tdata[118:103];
    in_req.bound_kind   = s_tdata[120:119];
    in_req.eval         = s_tdata[136:121];
    in_req.ply          = s_tdata[143:137];
    in_req.best_move    = s_tdata[159:144];
  end

  sattt_set_index #(
    .NUM_SETS (NUM_SETS),
    .SET_W    (SET_W)
  ) u_set_index (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && (in_req.kind != REQ_AGE)),
    .low_key (s_tdata[31:0]),
    .done    (idx_done),
    .set_idx (set_idx)
  );

  sattt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sattt_way_unit u_way_unit (
    .ent (entry),
    .req (req),
    .cfg (cfg),
    .res (wres)
  );

  // does the current way end the walk over the set
  always_comb begin
    case (req.kind)
      REQ_PROBE_SCORE: eval_stop = wres.hit && (!wres.deep || wres.none_score || wres.cut);
      REQ_PROBE_MOVE:  eval_stop = wres.hit;
      REQ_STORE:       eval_stop = pick_now;
      default:         eval_stop = 1'b1;
    endcase
  end

  // table port control
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cnt;
    ram_raddr = cnt;
    wr_entry  = entry;
    case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        wr_entry = '0;
      end
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = addr_way;
      end
      ST_EVAL: begin
        ram_waddr = addr_way;
        if (req.kind == REQ_PROBE_SCORE) begin
          // a usable hit clears its age
          ram_we       = wres.hit && wres.deep && !wres.none_score;
          wr_entry.age = '0;
        end else if (req.kind == REQ_STORE) begin
          ram_we = pick_now || (way == LAST_WAY);
          if (!pick_now) begin
            ram_waddr = addr_dflt;
          end
          wr_entry.tag   = req.key[63:32];
          wr_entry.depth = req.search_depth;
          wr_entry.score = req.score;
          wr_entry.bound = req.bound_kind;
          wr_entry.ply   = req.ply;
          wr_entry.move  = req.best_move;
          wr_entry.age   = '0;
          if (req.eval != cfg.none_code) begin
            wr_entry.eval = req.eval;
          end else if (pick_now || (way == req.key[WAY_W-1:0])) begin
            wr_entry.eval = entry.eval;
          end else begin
            wr_entry.eval = dflt_eval;
          end
        end
      end
      ST_AGE_READ: begin
        ram_re = 1'b1;
      end
      ST_AGE_WRITE: begin
        ram_we = 1'b1;
        if ((entry.tag != 32'd0) && (entry.age < cfg.age_limit)) begin
          wr_entry.age = entry.age + 8'd1;
        end else begin
          wr_entry.tag = '0;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    ram_wdata = ENTRY_W'(wr_entry);
  end

  // sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_CLEAR;
      cnt                 <= '0;
      way                 <= '0;
      m_tvalid            <= 1'b0;
      cfg.mate_threshold  <= 16'sd31000;
      cfg.mated_threshold <= -16'sd31000;
      cfg.age_limit       <= 8'd8;
      cfg.none_code       <= 16'sh8000;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MATE:      cfg.mate_threshold  <= cfg_data;
          CFG_MATED:     cfg.mated_threshold <= cfg_data;
          CFG_AGE_LIMIT: cfg.age_limit       <= cfg_data[7:0];
          CFG_NONE:      cfg.none_code       <= cfg_data;
          default:       cfg.none_code       <= cfg.none_code;
        endcase
      end
      // taken result clears, unless the next one is loaded this cycle
      if (m_tvalid && m_tready && (state != ST_RESULT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_ENTRY) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            req   <= in_req;
            way   <= '0;
            cnt   <= '0;
            sf    <= 1'b0;
            ef    <= 1'b0;
            mf    <= 1'b0;
            so    <= '0;
            eo    <= '0;
            mo    <= '0;
            state <= (in_req.kind == REQ_AGE) ? ST_AGE_READ : ST_INDEX;
          end
        end
        ST_INDEX: begin
          if (idx_done) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          // finish on a decision or after the last way, else step on
          if (eval_stop || (way == LAST_WAY)) begin
            state <= ST_RESULT;
          end else begin
            way   <= way + 1'b1;
            state <= ST_READ;
          end
          case (req.kind)
            REQ_PROBE_SCORE: begin
              if (wres.hit && wres.deep) begin
                ef <= 1'b1;
                eo <= entry.eval;
                if (!wres.none_score && wres.cut) begin
                  sf <= 1'b1;
                  so <= wres.cut_score;
                end
              end
            end
            REQ_PROBE_MOVE: begin
              if (wres.hit) begin
                mf <= 1'b1;
                mo <= entry.move;
              end
            end
            REQ_STORE: begin
              if (way == req.key[WAY_W-1:0]) begin
                dflt_eval <= entry.eval;
              end
            end
            default: begin
              // nothing to record for an age pass
            end
          endcase
        end
        ST_AGE_READ: begin
          state <= ST_AGE_WRITE;
        end
        ST_AGE_WRITE: begin
          if (cnt == LAST_ENTRY) begin
            state <= ST_RESULT;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_AGE_READ;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {mo, eo, so};
            m_tuser  <= {mf, ef, sf};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/sattt_ram.sv @@
`default_nettype none
module sattt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/sattt_set_index.sv @@
`default_nettype none
module sattt_set_index #(
  parameter int NUM_SETS = 1024,
  parameter int SET_W    = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [31:0]      low_key,
  output      logic             done,
  output      logic [SET_W-1:0] set_idx
);

  localparam bit IS_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;

  if (IS_POW2) begin : g_mask
    // power of two: the set is a mask of the low key
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      if (start) begin
        set_idx <= SET_W'(low_key & 32'(NUM_SETS - 1));
      end
    end
  end else begin : g_recip
    // reciprocal multiplication: quotient estimate is exact or one short,
    // so multiply back and finish with one compare and subtract
    localparam int          SHIFT   = 32 + SET_W;
    localparam logic [63:0] RECIP_F = (64'd1 << SHIFT) / 64'(NUM_SETS);
    localparam logic [32:0] RECIP   = RECIP_F[32:0];
    localparam logic [32:0] SETS_C  = 33'(NUM_SETS);

    logic [2:0]  stage;
    logic [31:0] low_q;
    logic [64:0] prod;
    logic [31:0] quot;
    logic [32:0] rem;

    always_ff @(posedge clk) begin
      if (rst) begin
        stage <= '0;
        done  <= 1'b0;
      end else begin
        stage <= {stage[1:0], start};
        done  <= stage[2];
      end
      if (start) begin
        low_q <= low_key;
        prod  <= 65'(low_key) * 65'(RECIP);
      end
      if (stage[0]) begin
        quot <= 32'(prod >> SHIFT);
      end
      if (stage[1]) begin
        rem <= 33'(low_q) - 33'(quot) * SETS_C;
      end
      if (stage[2]) begin
        set_idx <= (rem >= SETS_C) ? SET_W'(rem - SETS_C) : SET_W'(rem);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/sattt_way_unit.sv @@
`default_nettype none
module sattt_way_unit (
  input  wire sattt_pkg::entry_t ent,
  input  wire sattt_pkg::req_t   req,
  input  wire sattt_pkg::cfg_t   cfg,
  output sattt_pkg::way_res_t    res
);
  import sattt_pkg::*;

  localparam logic signed [17:0] SAT_HI = 18'sd32767;
  localparam logic signed [17:0] SAT_LO = -18'sd32768;

  logic signed [17:0] st_x;
  logic signed [17:0] mate_x;
  logic signed [17:0] mated_x;
  logic signed [17:0] ply_diff;
  logic signed [17:0] s_mate;
  logic signed [17:0] s_adj;
  logic signed [15:0] s_sat;

  // mate distance adjustment, then saturation
  always_comb begin
    st_x     = 18'($signed(ent.score));
    mate_x   = 18'($signed(cfg.mate_threshold));
    mated_x  = 18'($signed(cfg.mated_threshold));
    ply_diff = $signed({11'b0, ent.ply}) - $signed({11'b0, req.ply});
    s_mate   = (st_x >= mate_x) ? st_x + ply_diff : st_x;
    s_adj    = (s_mate <= mated_x) ? s_mate - ply_diff : s_mate;
    if (s_adj > SAT_HI) begin
      s_sat = 16'sh7FFF;
    end else if (s_adj < SAT_LO) begin
      s_sat = 16'sh8000;
    end else begin
      s_sat = s_adj[15:0];
    end
  end

  // tag, depth and cutoff decisions
  always_comb begin
    res.hit        = ent.tag == req.key[63:32];
    res.empty      = ent.tag == 32'd0;
    res.deep       = ent.depth >= req.search_depth;
    res.none_score = ent.score == cfg.none_code;
    res.cut        = 1'b0;
    res.cut_score  = s_sat;
    case (ent.bound)
      BOUND_EXACT: begin
        res.cut = 1'b1;
      end
      BOUND_UPPER: begin
        res.cut       = $signed(ent.score) <= $signed(req.alpha_bound);
        res.cut_score = req.alpha_bound;
      end
      BOUND_LOWER: begin
        res.cut       = $signed(ent.score) >= $signed(req.beta_bound);
        res.cut_score = req.beta_bound;
      end
      default: begin
        res.cut = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/sattt_checker.sv @@
`default_nettype none
`include "set_assoc_transposition_table_defines.svh"
module sattt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready
);

  // a stalled result holds
  `SATTT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // one request in work at a time
  `SATTT_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")

  // a score hit always carries an eval and never a move
  `SATTT_ASSERT_IMP(a_score_implies_eval, m_tvalid && m_tuser[0], m_tuser[1] && !m_tuser[2], "score found without eval or with move")

  // fields without a found flag are zero
  `SATTT_ASSERT_IMP(a_zero_unfound, m_tvalid, (m_tuser[0] || (m_tdata[15:0] == 16'h0)) && (m_tuser[1] || (m_tdata[31:16] == 16'h0)) && (m_tuser[2] || (m_tdata[47:32] == 16'h0)), "unfound field not zero")

endmodule

bind set_assoc_transposition_table sattt_checker u_sattt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
`default_nettype wire

@@ bench/set_assoc_transposition_table_tb.sv @@
module set_assoc_transposition_table_tb;
  import sattt_pkg::*;

  localparam int SETS          = 1024;
  localparam int TABLE_ENTRIES = SETS * NUM_WAYS;
  localparam int CYCLE_LIMIT   = 1000000;
  // bound code with no cutoff meaning
  localparam logic [1:0] BOUND_NONE = 2'd3;

  // expected contents of one result transaction
  typedef struct packed {
    logic               score_found;
    logic signed [15:0] score_out;
    logic               eval_found;
    logic signed [15:0] eval_out;
    logic               move_found;
    logic [15:0]        move_out;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // shadow copy of the table and of the registers
  entry_t             shadow_tbl [TABLE_ENTRIES];
  logic signed [15:0] mate_thr;
  logic signed [15:0] mated_thr;
  logic [7:0]         age_lim;
  logic signed [15:0] none_val;

  req_t   pending_reqs [$];
  reply_t expected_replies [$];
  req_t   on_bus;
  bit     took = 1'b0;
  int     burst_left = 1;
  int     gap_left = 0;
  int     stall_left = 0;
  int     cycles = 0;
  int     errors = 0;
  logic [9:0]  set_pool [6];
  logic [31:0] tag_pool [6];

  set_assoc_transposition_table #(
    .NUM_SETS(SETS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // apply one request to the shadow table and work out its result
  function automatic reply_t access_table(req_t r);
    reply_t      rep;
    logic [31:0] tag;
    int          idx;
    int          pick;
    int          w;
    int          s;
    int          st;
    bit          done;
    rep = '0;
    tag = r.key[63:32];
    done = 1'b0;
    case (r.kind)
      REQ_PROBE_SCORE: begin
        for (w = 0; w < NUM_WAYS && !done; w++) begin
          idx = {r.key[9:0], 2'(w)};
          if (shadow_tbl[idx].tag == tag) begin
            if (shadow_tbl[idx].depth < r.search_depth) begin
              done = 1'b1;
            end else begin
              rep.eval_found = 1'b1;
              rep.eval_out = shadow_tbl[idx].eval;
              st = shadow_tbl[idx].score;
              if (st == none_val) begin
                done = 1'b1;
              end else begin
                // mate scores move with the distance from the root
                s = st;
                if (s >= mate_thr) s = s + int'(shadow_tbl[idx].ply) - int'(r.ply);
                if (s <= mated_thr) s = s + int'(r.ply) - int'(shadow_tbl[idx].ply);
                shadow_tbl[idx].age = '0;
                if (shadow_tbl[idx].bound == BOUND_EXACT) begin
                  done = 1'b1;
                  rep.score_found = 1'b1;
                  if (s > 32767) rep.score_out = 16'h7FFF;
                  else if (s < -32768) rep.score_out = 16'h8000;
                  else rep.score_out = 16'(s);
                end else if (shadow_tbl[idx].bound == BOUND_UPPER && st <= r.alpha_bound) begin
                  done = 1'b1;
                  rep.score_found = 1'b1;
                  rep.score_out = r.alpha_bound;
                end else if (shadow_tbl[idx].bound == BOUND_LOWER && st >= r.beta_bound) begin
                  done = 1'b1;
                  rep.score_found = 1'b1;
                  rep.score_out = r.beta_bound;
                end
              end
            end
          end
        end
      end
      REQ_PROBE_MOVE: begin
        for (w = 0; w < NUM_WAYS && !done; w++) begin
          idx = {r.key[9:0], 2'(w)};
          if (shadow_tbl[idx].tag == tag) begin
            done = 1'b1;
            rep.move_found = 1'b1;
            rep.move_out = shadow_tbl[idx].move;
          end
        end
      end
      REQ_STORE: begin
        // first empty or matching way, else the way the key names
        pick = {r.key[9:0], r.key[1:0]};
        for (w = 0; w < NUM_WAYS && !done; w++) begin
          idx = {r.key[9:0], 2'(w)};
          if (shadow_tbl[idx].tag == '0 || shadow_tbl[idx].tag == tag) begin
            done = 1'b1;
            pick = idx;
          end
        end
        shadow_tbl[pick].tag = tag;
        shadow_tbl[pick].depth = r.search_depth;
        shadow_tbl[pick].score = r.score;
        shadow_tbl[pick].bound = r.bound_kind;
        if (r.eval != none_val) shadow_tbl[pick].eval = r.eval;
        shadow_tbl[pick].ply = r.ply;
        shadow_tbl[pick].move = r.best_move;
        shadow_tbl[pick].age = '0;
      end
      default: begin
        // age pass over the whole table
        for (idx = 0; idx < TABLE_ENTRIES; idx++) begin
          if (shadow_tbl[idx].tag != '0 && shadow_tbl[idx].age < age_lim)
            shadow_tbl[idx].age = shadow_tbl[idx].age + 8'd1;
          else
            shadow_tbl[idx].tag = '0;
        end
      end
    endcase
    return rep;
  endfunction

  // score-like value biased towards the interesting regions
  function automatic logic signed [15:0] pick_score();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0: v = none_val;
      1: v = mate_thr + 16'($urandom_range(0, 40));
      2: v = mated_thr - 16'($urandom_range(0, 40));
      3: v = 16'h7FFF;
      4: v = 16'h8000;
      5: v = 16'($urandom);
      default: v = 16'($urandom_range(0, 600)) - 16'sd300;
    endcase
    return v;
  endfunction

  // random request, mostly on a few crowded sets
  function automatic req_t make_req();
    req_t        r;
    int          roll;
    logic [31:0] low;
    roll = $urandom_range(0, 99);
    if (roll < 2) r.kind = REQ_AGE;
    else if (roll < 42) r.kind = REQ_PROBE_SCORE;
    else if (roll < 57) r.kind = REQ_PROBE_MOVE;
    else r.kind = REQ_STORE;
    low = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      r.key = {32'($urandom), low};
    end else begin
      low[9:0] = set_pool[$urandom_range(0, 5)];
      r.key = {tag_pool[$urandom_range(0, 5)], low};
    end
    r.search_depth = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12));
    r.alpha_bound = pick_score();
    r.beta_bound = pick_score();
    r.score = pick_score();
    r.bound_kind = 2'($urandom);
    r.eval = pick_score();
    r.ply = 7'($urandom);
    r.best_move = 16'($urandom);
    return r;
  endfunction

  task automatic push_req(input req_kind_t kind, input logic [63:0] key, input int depth,
                          input int alpha, input int beta, input int score,
                          input logic [1:0] bound, input int eval, input int ply,
                          input logic [15:0] move);
    req_t r;
    r.kind = kind;
    r.key = key;
    r.search_depth = 7'(depth);
    r.alpha_bound = 16'(alpha);
    r.beta_bound = 16'(beta);
    r.score = 16'(score);
    r.bound_kind = bound;
    r.eval = 16'(eval);
    r.ply = 7'(ply);
    r.best_move = move;
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_MATE:      mate_thr = val;
      CFG_MATED:     mated_thr = val;
      CFG_AGE_LIMIT: age_lim = val[7:0];
      default:       none_val = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int mate, input int mated, input int limit, input int none);
    write_reg(CFG_MATE, 16'(mate));
    write_reg(CFG_MATED, 16'(mated));
    write_reg(CFG_AGE_LIMIT, 16'(limit));
    write_reg(CFG_NONE, 16'(none));
  endtask

  // wait until every request has been sent and answered
  task automatic drain();
    while (pending_reqs.size() != 0 || s_tvalid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // sender: bursts of transactions with random gaps
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || took)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        on_bus = pending_reqs.pop_front();
        s_tdata <= {on_bus.best_move, on_bus.ply, on_bus.eval, on_bus.bound_kind, on_bus.score,
                    on_bus.beta_bound, on_bus.alpha_bound, on_bus.search_depth, on_bus.key};
        s_tuser <= on_bus.kind;
        s_tvalid <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, with quiet stretches
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (cycles[10:9] != 2'd0 && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  // predict on each accepted request, check each result transaction
  always @(posedge clk) begin
    reply_t rep;
    if (rst) begin
      took = 1'b0;
    end else begin
      took = s_tvalid && s_tready;
      if (took) expected_replies.push_back(access_table(on_bus));
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          $error("result transaction with nothing outstanding");
          errors++;
        end else begin
          rep = expected_replies.pop_front();
          check_field("score_found", rep.score_found, m_tuser[0]);
          check_field("score_out", rep.score_out, $signed(m_tdata[15:0]));
          check_field("eval_found", rep.eval_found, m_tuser[1]);
          check_field("eval_out", rep.eval_out, $signed(m_tdata[31:16]));
          check_field("move_found", rep.move_found, m_tuser[2]);
          check_field("move_out", {16'h0, rep.move_out}, {16'h0, m_tdata[47:32]});
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("set_assoc_transposition_table_tb: errors");
      $finish;
    end
  end

  initial begin
    int i;
    int ph;
    for (i = 0; i < TABLE_ENTRIES; i++) shadow_tbl[i] = '0;
    mate_thr = 16'sd31000;
    mated_thr = -16'sd31000;
    age_lim = 8'd8;
    none_val = 16'h8000;
    set_pool = '{10'd0, 10'd1, 10'd5, 10'd512, 10'd700, 10'd1023};
    tag_pool[0] = 32'h0;
    tag_pool[1] = 32'hFFFF_FFFF;
    for (i = 2; i < 6; i++) tag_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_config(31000, -31000, 8, -32768);

    // directed: hits, misses, cutoffs, replacement, saturation, no-value marker
    push_req(REQ_PROBE_SCORE, {32'h1111_0001, 32'd5}, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    push_req(REQ_PROBE_MOVE, {32'h1111_0001, 32'd5}, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    push_req(REQ_STORE, {32'h1111_0001, 32'd5}, 10, 0, 0, 100, BOUND_EXACT, 50, 3, 16'h1234);
    push_req(REQ_PROBE_SCORE, {32'h1111_0001, 32'd5}, 10, 0, 0, 0, BOUND_EXACT, 0, 9, 16'h0);
    push_req(REQ_PROBE_SCORE, {32'h1111_0001, 32'd5}, 11, 0, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    push_req(REQ_PROBE_MOVE, {32'h1111_0001, 32'd5}, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    push_req(REQ_STORE, {32'h1111_0001, 32'd5}, 127, 0, 0, 31500, BOUND_EXACT, -32768, 0,
             16'h4321);
    push_req(REQ_PROBE_SCORE, {32'h1111_0001, 32'd5}, 0, 0, 0, 0, BOUND_EXACT, 0, 5, 16'h0);
    push_req(REQ_STORE, {32'h2222_0002, 32'd5}, 5, 0, 0, -200, BOUND_UPPER, 7, 127, 16'hFFFF);
    push_req(REQ_PROBE_SCORE, {32'h2222_0002, 32'd5}, 0, -100, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    push_req(REQ_PROBE_SCORE, {32'h2222_0002, 32'd5}, 0, -300, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    push_req(REQ_STORE, {32'h3333_0003, 32'd5}, 5, 0, 0, 300, BOUND_LOWER, -7, 1, 16'h0);
    push_req(REQ_PROBE_SCORE, {32'h3333_0003, 32'd5}, 0, 0, 200, 0, BOUND_EXACT, 0, 0, 16'h0);
    push_req(REQ_STORE, {32'h4444_0004, 32'd5}, 5, 0, 0, 5, BOUND_NONE, 1, 2, 16'h0);
    push_req(REQ_PROBE_SCORE, {32'h4444_0004, 32'd5}, 0, 100, -100, 0, BOUND_EXACT, 0, 0,
             16'h0);
    // full set: the key picks the victim way
    push_req(REQ_STORE, {32'h5555_0005, 32'hFFFF_FC05}, 3, 0, 0, 9, BOUND_EXACT, 2, 0, 16'h55);
    push_req(REQ_PROBE_SCORE, {32'h2222_0002, 32'd5}, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    // zero tag matches an empty entry
    push_req(REQ_PROBE_SCORE, {32'h0, 32'd7}, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    // mate adjustment beyond the 16-bit range
    push_req(REQ_STORE, {32'h6666_0006, 32'd9}, 0, 0, 0, 32767, BOUND_EXACT, 32767, 127, 16'h6);
    push_req(REQ_PROBE_SCORE, {32'h6666_0006, 32'd9}, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    push_req(REQ_STORE, {32'h7777_0007, 32'd10}, 0, 0, 0, -32767, BOUND_EXACT, -1, 127, 16'h7);
    push_req(REQ_PROBE_SCORE, {32'h7777_0007, 32'd10}, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    // stored score equal to the no-value marker
    push_req(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 127, 0, 0, -32768, BOUND_EXACT, 9, 127,
             16'hFFFF);
    push_req(REQ_PROBE_SCORE, 64'hFFFF_FFFF_FFFF_FFFF, 127, 32767, 32767, 0, BOUND_EXACT, 0,
             127, 16'h0);
    push_req(REQ_AGE, 64'h0, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 16'h0);
    push_req(REQ_PROBE_MOVE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, BOUND_EXACT, 0, 0, 16'h0);

    // random phases, each under its own register setting
    for (ph = 0; ph < 6; ph++) begin
      drain();
      repeat (8) @(posedge clk);
      case (ph)
        0: set_config(31000, -31000, 8, -32768);
        1: set_config(32767, -32768, 0, 32767);
        2: set_config(-32768, 32767, 255, 0);
        default: set_config(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                            $urandom_range(1, 3), $urandom_range(0, 600) - 300);
      endcase
      repeat ((ph == 0) ? 210 : (ph < 3) ? 100 : 115) pending_reqs.push_back(make_req());
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("set_assoc_transposition_table_tb: clean");
    end else begin
      $display("set_assoc_transposition_table_tb: errors");
    end
    $finish;
  end

endmodule
